// File: rtl/cossim_pkg.sv
// Shared types and constants of the cosine similarity accumulator.
`default_nettype none

package cossim_pkg;

	localparam int ELEM_PORT_W = 16;
	localparam int COS_W = 16;
	localparam int DOT_W = 48;
	localparam int HALF_W = DOT_W / 2;
	localparam int PROD_W = 2 * DOT_W;
	localparam int K_W = 16;
	localparam int IDX_W = 4;
	localparam int T_SHIFT = 30;
	localparam int Q_W = PROD_W + K_W;
	localparam int SRCH_W = 128;
	localparam int STEP_W = 3;

	localparam logic [IDX_W-1:0] K_TOP = IDX_W'(K_W - 1);
	localparam logic [IDX_W-1:0] K_BOTTOM = '0;
	localparam logic [STEP_W-1:0] MUL_LAST = '1;
	localparam logic signed [COS_W-1:0] COS_MAX = {1'b0, {(COS_W-1){1'b1}}};

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_MUL,
		ST_MDRAIN,
		ST_SRCH_A,
		ST_SRCH_B,
		ST_FIN
	} ctrl_state_t;

	typedef struct packed {
		logic              acc_en;
		logic              last;
		logic              mul_en;
		logic [STEP_W-1:0] mul_step;
		logic              cand_en;
		logic              upd_en;
		logic [IDX_W-1:0]  bit_idx;
		logic              res_load;
	} cmd_t;

	typedef struct packed {
		logic pass;
		logic out_free;
	} sts_t;

endpackage

`default_nettype wire

// File: rtl/cossim_in_if.sv
// Element pair channel: valid/ready handshake with the two elements and the last mark.
`default_nettype none

interface cossim_in_if;
	import cossim_pkg::*;

	logic                          valid;
	logic                          ready;
	logic signed [ELEM_PORT_W-1:0] elem_a;
	logic signed [ELEM_PORT_W-1:0] elem_b;
	logic                          last;

	modport source (output valid, output elem_a, output elem_b, output last, input ready);
	modport sink (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

`default_nettype wire

// File: rtl/cossim_out_if.sv
// Result channel: valid/ready handshake with the cosine and the zero-dot flag.
`default_nettype none

interface cossim_out_if;
	import cossim_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [COS_W-1:0] cosine;
	logic                    dot_was_zero;

	modport source (output valid, output cosine, output dot_was_zero, input ready);
	modport sink (input valid, input cosine, input dot_was_zero, output ready);
endinterface

`default_nettype wire

// File: rtl/cossim_ctrl.sv
// Controller: accumulate, multiply, bitwise root search and result hand-off sequencing.
`default_nettype none

module cossim_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_last,
	output logic               in_ready,
	input  cossim_pkg::sts_t   sts,
	output cossim_pkg::cmd_t   cmd
);
	import cossim_pkg::*;

	ctrl_state_t       state_q;
	ctrl_state_t       state_d;
	logic [STEP_W-1:0] step_q;
	logic [IDX_W-1:0]  j_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_ACCUM;
			step_q  <= '0;
			j_q     <= K_TOP;
		end else begin
			state_q <= state_d;
			if (state_q == ST_MUL) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
			if (state_q == ST_MDRAIN) begin
				j_q <= K_TOP;
			end else if (state_q == ST_SRCH_B && state_d == ST_SRCH_A) begin
				j_q <= j_q - 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_ACCUM: begin
				if (in_valid && in_last) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				if (step_q == MUL_LAST) begin
					state_d = ST_MDRAIN;
				end
			end
			ST_MDRAIN: state_d = ST_SRCH_A;
			ST_SRCH_A: state_d = ST_SRCH_B;
			ST_SRCH_B: begin
				if ((sts.pass && j_q == K_TOP) || j_q == K_BOTTOM) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_SRCH_A;
				end
			end
			ST_FIN: begin
				if (sts.out_free) begin
					state_d = ST_ACCUM;
				end
			end
			default: state_d = ST_ACCUM;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.mul_step = step_q;
		cmd.bit_idx  = j_q;
		cmd.last     = in_last;
		case (state_q)
			ST_ACCUM: begin
				in_ready   = 1'b1;
				cmd.acc_en = in_valid;
			end
			ST_MUL:    cmd.mul_en = 1'b1;
			ST_MDRAIN: cmd.mul_en = 1'b0;
			ST_SRCH_A: cmd.cand_en = 1'b1;
			ST_SRCH_B: cmd.upd_en = 1'b1;
			ST_FIN:    cmd.res_load = sts.out_free;
			default:   cmd.acc_en = 1'b0;
		endcase
	end

	a_idx_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SRCH_B && state_d == ST_SRCH_A) |=> (j_q == $past(j_q) - 1'b1))
		else $error("search index did not step down by one");

endmodule

`default_nettype wire

// File: rtl/cossim_dp.sv
// Datapath: saturating MAC accumulators, shared 24x24 multiplier, root search registers.
`default_nettype none

module cossim_dp #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  cossim_pkg::cmd_t                          cmd,
	output cossim_pkg::sts_t                          sts,
	input  logic signed [cossim_pkg::ELEM_PORT_W-1:0] elem_a,
	input  logic signed [cossim_pkg::ELEM_PORT_W-1:0] elem_b,
	input  logic                                      out_ready,
	output logic                                      out_valid,
	output logic signed [cossim_pkg::COS_W-1:0]       cosine,
	output logic                                      dot_was_zero
);
	import cossim_pkg::*;

	localparam int EW = ELEM_WIDTH;
	localparam int EXT_W = 2 * ELEM_PORT_W;
	localparam int PAD_W = DOT_W + 1 - 2 * EW;

	logic [EXT_W-1:0]         a_z;
	logic [EXT_W-1:0]         b_z;
	logic signed [EW-1:0]     a_e;
	logic signed [EW-1:0]     b_e;
	logic signed [2*EW-1:0]   ab;
	logic signed [2*EW-1:0]   aa;
	logic signed [2*EW-1:0]   bb;
	logic signed [DOT_W:0]    dot_sum;
	logic [DOT_W:0]           na_sum;
	logic [DOT_W:0]           nb_sum;
	logic signed [DOT_W-1:0]  dot_next;
	logic [DOT_W-1:0]         na_next;
	logic [DOT_W-1:0]         nb_next;

	logic signed [DOT_W-1:0]  dot_q;
	logic [DOT_W-1:0]         na_q;
	logic [DOT_W-1:0]         nb_q;
	logic [DOT_W-1:0]         mag_q;
	logic                     neg_q;
	logic                     zero_q;
	logic [DOT_W-1:0]         naop_q;
	logic [DOT_W-1:0]         nbop_q;

	logic [DOT_W-1:0]         mx;
	logic [DOT_W-1:0]         my;
	logic [HALF_W-1:0]        mx_h;
	logic [HALF_W-1:0]        my_h;
	logic [DOT_W-1:0]         mul_s1;
	logic [1:0]               shf_s1;
	logic                     dst_s1;
	logic                     ppv_s1;
	logic [PROD_W-1:0]        pp_sh;
	logic [PROD_W-1:0]        t_q;
	logic [PROD_W-1:0]        p_q;

	logic [SRCH_W-1:0]        s_q;
	logic [Q_W-1:0]           q_q;
	logic [SRCH_W-1:0]        cand_q;
	logic [SRCH_W-1:0]        cand;
	logic [SRCH_W-1:0]        t_sh;
	logic [K_W-1:0]           k_q;
	logic [IDX_W:0]           j_p1;
	logic signed [COS_W-1:0]  res_cos;

	logic signed [COS_W-1:0]  out_cos_q;
	logic                     out_zero_q;
	logic                     out_vld_q;

	// element decode: low EW bits, two's complement
	assign a_z = {{ELEM_PORT_W{1'b0}}, elem_a};
	assign b_z = {{ELEM_PORT_W{1'b0}}, elem_b};
	assign a_e = a_z[EW-1:0];
	assign b_e = b_z[EW-1:0];
	assign ab  = a_e * b_e;
	assign aa  = a_e * a_e;
	assign bb  = b_e * b_e;

	always_comb begin
		dot_sum = {dot_q[DOT_W-1], dot_q} + {{PAD_W{ab[2*EW-1]}}, ab};
		na_sum  = {1'b0, na_q} + {{PAD_W{1'b0}}, aa};
		nb_sum  = {1'b0, nb_q} + {{PAD_W{1'b0}}, bb};
		if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
			dot_next = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
		end else begin
			dot_next = dot_sum[DOT_W-1:0];
		end
		na_next = na_sum[DOT_W] ? '1 : na_sum[DOT_W-1:0];
		nb_next = nb_sum[DOT_W] ? '1 : nb_sum[DOT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			na_q  <= '0;
			nb_q  <= '0;
		end else if (cmd.acc_en) begin
			if (cmd.last) begin
				dot_q <= '0;
				na_q  <= '0;
				nb_q  <= '0;
			end else begin
				dot_q <= dot_next;
				na_q  <= na_next;
				nb_q  <= nb_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_en && cmd.last) begin
			mag_q  <= dot_next[DOT_W-1] ? DOT_W'(-dot_next) : DOT_W'(dot_next);
			neg_q  <= dot_next[DOT_W-1];
			zero_q <= (dot_next == '0);
			naop_q <= na_next;
			nbop_q <= nb_next;
		end
	end

	// 48x48 products as four 24x24 partials: step[2] picks the product, step[1:0] the halves
	always_comb begin
		mx   = cmd.mul_step[2] ? naop_q : mag_q;
		my   = cmd.mul_step[2] ? nbop_q : mag_q;
		mx_h = cmd.mul_step[1] ? mx[DOT_W-1:HALF_W] : mx[HALF_W-1:0];
		my_h = cmd.mul_step[0] ? my[DOT_W-1:HALF_W] : my[HALF_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppv_s1 <= 1'b0;
		end else begin
			ppv_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		mul_s1 <= mx_h * my_h;
		shf_s1 <= 2'(cmd.mul_step[1]) + 2'(cmd.mul_step[0]);
		dst_s1 <= cmd.mul_step[2];
	end

	always_comb begin
		case (shf_s1)
			2'd0:    pp_sh = {{DOT_W{1'b0}}, mul_s1};
			2'd1:    pp_sh = {{HALF_W{1'b0}}, mul_s1, {HALF_W{1'b0}}};
			default: pp_sh = {mul_s1, {DOT_W{1'b0}}};
		endcase
	end

	// largest k (ends at k=2^15 if that passes) with k^2*P <= mag^2*2^30, bit by bit:
	// s = k^2*P, q = k*P, candidate = s + q*2^(j+1) + P*2^(2j)
	assign j_p1 = {1'b0, cmd.bit_idx} + 1'b1;
	assign t_sh = {{(SRCH_W-PROD_W-T_SHIFT){1'b0}}, t_q, {T_SHIFT{1'b0}}};
	assign cand = s_q
		+ ({{(SRCH_W-Q_W){1'b0}}, q_q} << j_p1)
		+ ({{(SRCH_W-PROD_W){1'b0}}, p_q} << {cmd.bit_idx, 1'b0});

	always_ff @(posedge clk) begin
		if (cmd.acc_en && cmd.last) begin
			t_q <= '0;
			p_q <= '0;
			s_q <= '0;
			q_q <= '0;
			k_q <= '0;
		end else begin
			if (ppv_s1) begin
				if (dst_s1) begin
					p_q <= p_q + pp_sh;
				end else begin
					t_q <= t_q + pp_sh;
				end
			end
			if (cmd.cand_en) begin
				cand_q <= cand;
			end
			if (cmd.upd_en && sts.pass) begin
				s_q            <= cand_q;
				q_q            <= q_q + ({{(Q_W-PROD_W){1'b0}}, p_q} << cmd.bit_idx);
				k_q[cmd.bit_idx] <= 1'b1;
			end
		end
	end

	assign sts.pass     = (cand_q <= t_sh);
	assign sts.out_free = !out_vld_q || out_ready;

	always_comb begin
		if (zero_q) begin
			res_cos = '0;
		end else if (neg_q) begin
			res_cos = COS_W'(-k_q);
		end else if (k_q[K_W-1]) begin
			res_cos = COS_MAX;
		end else begin
			res_cos = k_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_cos_q  <= res_cos;
			out_zero_q <= zero_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign cosine       = out_cos_q;
	assign dot_was_zero = out_zero_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> !(out_vld_q && !out_ready))
		else $error("pending result overwritten");

	a_pos_sign: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_load && !zero_q && !neg_q) |=> !out_cos_q[COS_W-1])
		else $error("positive dot gave negative cosine");

	a_sums_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.acc_en && cmd.last) |=> (dot_q == '0 && na_q == '0 && nb_q == '0))
		else $error("sums not cleared after last pair");

endmodule

`default_nettype wire

// File: rtl/cosine_similarity_accumulator.sv
// Cosine similarity accumulator: top level joining controller and datapath.
//
// Usage: element pairs (signed Q8.8) arrive on the pairs channel, one transaction
// per cycle while the block accumulates. Each pair adds a*b to a saturating
// 48-bit dot sum and a^2, b^2 to two saturating 48-bit norm sums.
// A pair with last set closes the vector: pairs.ready drops while the cosine
// is computed, and the sums are cleared for the next vector.
// After the last pair, the shared 24x24 multiplier forms mag^2 and normA*normB
// as four partials each, a drain state follows, then the shift-and-add root
// search settles 1 to 16 result bits from the top, and a load state moves the
// result to the output register. Throughput is one pair per cycle within a
// vector, with pairs.ready low from the last pair until the result is loaded.
// The result is a signed Q1.15 cosine, truncated toward zero, +1 saturated to
// 32767; a zero dot product gives 0 with dot_was_zero set.
// The result sits in an output register; the next vector is accepted while it
// waits. If a second result completes before the first is taken, the block
// holds it and keeps pairs.ready low until result.ready frees the register.
// Reset clears the sums and the controller; no result is pending after it.
`default_nettype none

module cosine_similarity_accumulator #(
	parameter int ELEM_WIDTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cossim_in_if.sink  pairs,
	cossim_out_if.source result
);
	import cossim_pkg::*;

	cmd_t cmd;
	sts_t sts;
	logic in_ready;

	assign pairs.ready = in_ready;

	cossim_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pairs.valid),
		.in_last  (pairs.last),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	cossim_dp #(
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.elem_a       (pairs.elem_a),
		.elem_b       (pairs.elem_b),
		.out_ready    (result.ready),
		.out_valid    (result.valid),
		.cosine       (result.cosine),
		.dot_was_zero (result.dot_was_zero)
	);

endmodule

`default_nettype wire
